// ===== hw/rtl/sensor_packet_deframer_defines.svh =====
// Assertion helpers for the packet deframer. The enclosing module must have
// clk and rst_n in scope; every check is disabled while reset is asserted.
`ifndef SENSOR_PACKET_DEFRAMER_DEFINES_SVH
`define SENSOR_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication.
`define SPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spd check failed");

// Implication whose consequent is checked in the next cycle.
`define SPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spd check failed");

`endif

// ===== hw/rtl/spd_pkg.sv =====
`timescale 1ns / 1ps
package spd_pkg;

  localparam int TICK_W = 20;
  localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd50000;

  localparam logic [7:0]  HDR_FIRST  = 8'hEF;
  localparam logic [7:0]  HDR_SECOND = 8'h01;
  localparam logic [15:0] ADDR_BYTES = 16'd4;
  localparam logic [15:0] LEN_OVERHEAD = 16'd2;

  localparam logic FUNC_TICK = 1'b1;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Register index decoded from the address bit above the byte lanes.
  localparam logic REG_BYTE_TIMEOUT = 1'b0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HEADER  = 3'd1,
    ST_SUM     = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_LENGTH  = 3'd4
  } spd_status_t;

  // One classified input item.
  typedef struct packed {
    logic       is_tick;
    logic       is_first;
    logic       is_second;
    logic [7:0] data;
  } spd_cmd_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  package_id;
    logic [8:0]  payload_length;
    spd_status_t status;
  } spd_res_t;

endpackage

// ===== hw/rtl/spd_fifo.sv =====
`timescale 1ns / 1ps
module spd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          push_ok, pop_ok;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/spd_front.sv =====
`timescale 1ns / 1ps
module spd_front
  import spd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  input  logic       cmd_pop,
  output spd_cmd_t   cmd,
  output logic       cmd_empty
);

  spd_cmd_t cls;

  // Header bytes are recognized here so the sequencer only tests flags.
  always_comb begin
    cls.is_tick   = (in_func == FUNC_TICK);
    cls.is_first  = (in_rx_byte == HDR_FIRST);
    cls.is_second = (in_rx_byte == HDR_SECOND);
    cls.data      = in_rx_byte;
  end

  spd_fifo #(
    .W     ($bits(spd_cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// ===== hw/rtl/spd_back.sv =====
`timescale 1ns / 1ps
`include "sensor_packet_deframer_defines.svh"
module spd_back
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TICK_W-1:0] byte_timeout,
  input  spd_cmd_t          cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output spd_res_t          res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR2, PH_ADDR, PH_ID, PH_LENH, PH_LENL, PH_DATA, PH_SUMH, PH_SUML
  } phase_t;

  localparam logic [15:0] MAX_P = 16'(MAX_PAYLOAD);

  phase_t            phase_r, phase_nxt;
  logic              hdr_ok_r, hdr_ok_nxt;
  logic [15:0]       field_count_r, field_count_nxt;
  logic [15:0]       running_sum_r, running_sum_nxt;
  logic [7:0]        sum_hi_r, sum_hi_nxt;
  logic [15:0]       payload_total_r, payload_total_nxt;
  logic [7:0]        current_id_r, current_id_nxt;
  logic [TICK_W-1:0] idle_ticks_r, idle_ticks_nxt;

  logic              step;
  logic [TICK_W-1:0] ticks_inc;
  logic [15:0]       sum_add;
  logic [15:0]       len_full;
  logic [16:0]       len_m2;
  logic              len_bad;
  logic [15:0]       count_inc;

  assign step      = !cmd_empty && !res_full;
  assign cmd_pop   = step;
  assign ticks_inc = (idle_ticks_r == TICK_MAX) ? idle_ticks_r : idle_ticks_r + 1'b1;
  assign sum_add   = running_sum_r + {8'd0, cmd.data};
  assign len_full  = {payload_total_r[15:8], cmd.data};
  assign len_m2    = {1'b0, len_full} - {1'b0, LEN_OVERHEAD};
  assign len_bad   = len_m2[16] || (len_m2[15:0] > MAX_P);
  assign count_inc = field_count_r + 1'b1;

  always_comb begin
    phase_nxt         = phase_r;
    hdr_ok_nxt        = hdr_ok_r;
    field_count_nxt   = field_count_r;
    running_sum_nxt   = running_sum_r;
    sum_hi_nxt        = sum_hi_r;
    payload_total_nxt = payload_total_r;
    current_id_nxt    = current_id_r;
    idle_ticks_nxt    = idle_ticks_r;
    res_push           = 1'b0;
    res.kind           = KIND_END;
    res.data_byte      = '0;
    res.byte_index     = '0;
    res.package_id     = current_id_r;
    res.payload_length = '0;
    res.status         = ST_OK;

    if (step) begin
      if (cmd.is_tick) begin
        if (phase_r != PH_IDLE) begin
          idle_ticks_nxt = ticks_inc;
          if (ticks_inc >= byte_timeout) begin
            phase_nxt      = PH_IDLE;
            idle_ticks_nxt = '0;
            res_push       = 1'b1;
            res.status     = ST_TIMEOUT;
          end
        end
      end else begin
        idle_ticks_nxt = '0;
        unique case (phase_r)
          PH_IDLE: begin
            hdr_ok_nxt     = cmd.is_first;
            current_id_nxt = '0;
            phase_nxt      = PH_HDR2;
          end
          PH_HDR2: begin
            if (hdr_ok_r && cmd.is_second) begin
              field_count_nxt = '0;
              phase_nxt       = PH_ADDR;
            end else begin
              phase_nxt  = PH_IDLE;
              res_push   = 1'b1;
              res.status = ST_HEADER;
            end
          end
          PH_ADDR: begin
            field_count_nxt = count_inc;
            if (count_inc >= ADDR_BYTES) begin
              phase_nxt = PH_ID;
            end
          end
          PH_ID: begin
            current_id_nxt  = cmd.data;
            running_sum_nxt = {8'd0, cmd.data};
            phase_nxt       = PH_LENH;
          end
          PH_LENH: begin
            payload_total_nxt = {cmd.data, 8'd0};
            running_sum_nxt   = sum_add;
            phase_nxt         = PH_LENL;
          end
          PH_LENL: begin
            running_sum_nxt = sum_add;
            if (len_bad) begin
              phase_nxt  = PH_IDLE;
              res_push   = 1'b1;
              res.status = ST_LENGTH;
            end else begin
              payload_total_nxt = len_m2[15:0];
              field_count_nxt   = '0;
              phase_nxt         = (len_m2[15:0] == '0) ? PH_SUMH : PH_DATA;
            end
          end
          PH_DATA: begin
            running_sum_nxt = sum_add;
            field_count_nxt = count_inc;
            if (count_inc >= payload_total_r) begin
              phase_nxt = PH_SUMH;
            end
            res_push       = 1'b1;
            res.kind       = KIND_DATA;
            res.data_byte  = cmd.data;
            res.byte_index = field_count_r[7:0];
          end
          PH_SUMH: begin
            sum_hi_nxt = cmd.data;
            phase_nxt  = PH_SUML;
          end
          PH_SUML: begin
            phase_nxt = PH_IDLE;
            res_push  = 1'b1;
            if ({sum_hi_r, cmd.data} != running_sum_r) begin
              res.status = ST_SUM;
            end else begin
              res.status         = ST_OK;
              res.payload_length = payload_total_r[8:0];
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      hdr_ok_r        <= 1'b0;
      field_count_r   <= '0;
      running_sum_r   <= '0;
      sum_hi_r        <= '0;
      payload_total_r <= '0;
      current_id_r    <= '0;
      idle_ticks_r    <= '0;
    end else begin
      phase_r         <= phase_nxt;
      hdr_ok_r        <= hdr_ok_nxt;
      field_count_r   <= field_count_nxt;
      running_sum_r   <= running_sum_nxt;
      sum_hi_r        <= sum_hi_nxt;
      payload_total_r <= payload_total_nxt;
      current_id_r    <= current_id_nxt;
      idle_ticks_r    <= idle_ticks_nxt;
    end
  end

  // The tick counter only runs inside a packet.
  `SPD_ASSERT_NOW(a_idle_no_ticks, phase_r == PH_IDLE, idle_ticks_r == '0)
  // A received byte always restarts the inter-byte timer.
  `SPD_ASSERT_NEXT(a_byte_clears_ticks, step && !cmd.is_tick, idle_ticks_r == '0)
  // While streaming, at least one payload byte is still owed.
  `SPD_ASSERT_NOW(a_data_in_range, phase_r == PH_DATA,
                  payload_total_r != '0 && field_count_r < payload_total_r)
  // Payload results never carry a status or a length.
  `SPD_ASSERT_NOW(a_data_result_clean, res_push && res.kind == KIND_DATA,
                  res.status == ST_OK && res.payload_length == '0)

endmodule

// ===== hw/rtl/sensor_packet_deframer.sv =====
`timescale 1ns / 1ps
// Path: an item is registered in the command queue, and the sequencer's result is registered in the output queue.
// Throughput: one item (byte or tick) per cycle, sustained, while results are popped.
// The figure is set by the packet sequencer, which retires one queued item a cycle unless it is stalled.
// Reset (rst_n low at a clock edge) empties both queues, returns the sequencer to idle
// and loads byte_timeout with 50000; there is no clearing pass, so the block is ready at once.
module sensor_packet_deframer
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256,
  parameter int CMD_DEPTH   = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [7:0]  in_rx_byte,
  // Result channel.
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_index,
  output logic [7:0]  out_package_id,
  output logic [8:0]  out_payload_length,
  output logic [2:0]  out_status,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The configuration port holds a single register, byte_timeout, at byte address 0.
  // A write transfer completes in the access cycle; pready is tied high so there
  // are never wait states. Writes to the unused word are dropped.
  logic [TICK_W-1:0] byte_timeout_r, byte_timeout_nxt;
  logic              cfg_wr;
  logic              cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == REG_BYTE_TIMEOUT);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = cfg_sel ? {{(32-TICK_W){1'b0}}, byte_timeout_r} : '0;

  always_comb begin
    byte_timeout_nxt = byte_timeout_r;
    if (cfg_wr && cfg_sel) begin
      byte_timeout_nxt = pwdata[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_timeout_r <= TIMEOUT_RESET;
    end else begin
      byte_timeout_r <= byte_timeout_nxt;
    end
  end

  // The front end classifies each incoming transfer and parks it in a short
  // command queue, so input transfers keep flowing while the result side stalls, until the queue fills.
  spd_cmd_t cmd;
  logic     cmd_empty;
  logic     cmd_pop;

  spd_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty)
  );

  // The back end walks the packet format one item per cycle. It only takes a
  // command when the result queue has room, since any item may produce a result.
  spd_res_t res;
  logic     res_push;
  logic     res_full;

  spd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_timeout (byte_timeout_r),
    .cmd          (cmd),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res)
  );

  // Results wait in a small output queue; the oldest one drives the out_ ports.
  spd_res_t res_head;

  spd_fifo #(
    .W     ($bits(spd_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_kind           = res_head.kind;
  assign out_data_byte      = res_head.data_byte;
  assign out_byte_index     = res_head.byte_index;
  assign out_package_id     = res_head.package_id;
  assign out_payload_length = res_head.payload_length;
  assign out_status         = res_head.status;

endmodule
